@@ hdl/proximity_dedup_ring_table_top_macros.svh @@
// Assertion macros for the proximity dedup ring table checker.
// Used by hdl/pdrt_checker.sv; depends on nothing else.
`ifndef PROXIMITY_DEDUP_RING_TABLE_TOP_MACROS_SVH
`define PROXIMITY_DEDUP_RING_TABLE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define PDRT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PDRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/pdrt_pkg.sv @@
// Shared types and constants for the proximity dedup ring table.
// No dependencies; used by every module in hdl/.
package pdrt_pkg;

    localparam int POS_W  = 15;
    localparam int SLOT_W = 6;
    localparam int HALF_W = 8;

    localparam logic [HALF_W-1:0] HALF_RESET = 8'd24;

    localparam logic FUNC_PLACE  = 1'b0;
    localparam logic FUNC_EXPIRE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
    } t_center;

    typedef struct packed {
        logic in_window;  // point inside the entry's square window
        logic exact;      // point equals the stored center
    } t_match;

endpackage

@@ hdl/pdrt_window_match.sv @@
// Window and equality compare of one point against one stored center.
// Depends on pdrt_pkg.
module pdrt_window_match (
    input  pdrt_pkg::t_center           i_center,
    input  logic [pdrt_pkg::POS_W-1:0]  i_pos_x,
    input  logic [pdrt_pkg::POS_W-1:0]  i_pos_y,
    input  logic [pdrt_pkg::HALF_W-1:0] i_half,
    output pdrt_pkg::t_match            o_match
);

    localparam int EW = pdrt_pkg::POS_W + 1;
    localparam int PADW = EW - pdrt_pkg::HALF_W;

    logic [EW-1:0] px_ext, py_ext, cx_ext, cy_ext, half_ext;
    logic          x_ok, y_ok;

    assign px_ext   = {1'b0, i_pos_x};
    assign py_ext   = {1'b0, i_pos_y};
    assign cx_ext   = {1'b0, i_center.x};
    assign cy_ext   = {1'b0, i_center.y};
    assign half_ext = {{PADW{1'b0}}, i_half};

    // c - h <= p < c + h, rearranged to stay unsigned
    assign x_ok = ((px_ext + half_ext) >= cx_ext) && (px_ext < (cx_ext + half_ext));
    assign y_ok = ((py_ext + half_ext) >= cy_ext) && (py_ext < (cy_ext + half_ext));

    assign o_match.in_window = x_ok && y_ok;
    assign o_match.exact     = (i_center.x == i_pos_x) && (i_center.y == i_pos_y);

endmodule

@@ hdl/proximity_dedup_ring_table_top.sv @@
// Proximity dedup ring table: input/output channels, config register and
// scan sequencer around the center memory. Depends on pdrt_pkg, pdrt_window_match.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one transaction: func,
//   pos_x, pos_y, slot. Output channel (o_out_valid / i_out_stall) returns one
//   transaction per input: accepted, slot_used.
//   Config channel (i_cfg_valid / o_cfg_ready) writes half_window; ready is
//   always high. Write it only while no transaction is in flight.
//   One item at a time. A place reads every table entry through the single
//   read port of the center memory, one per cycle, in SCAN, then passes WAIT
//   and FINISH before the result register is loaded; the next item can be
//   taken once the result is registered. An expire reads one entry.
//   The result sits in an output register; the next item may be accepted
//   while it waits. If the receiver still stalls when the following result is
//   ready, the sequencer holds in its final state and o_in_stall stays high.
//   Reset (synchronous, active low) clears all valid bits, the ring pointer
//   and the output register, and loads half_window with 24. No clearing pass.
module proximity_dedup_ring_table_top #(
    parameter int ENTRIES = 40
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_func,
    input  logic [pdrt_pkg::POS_W-1:0]    i_pos_x,
    input  logic [pdrt_pkg::POS_W-1:0]    i_pos_y,
    input  logic [pdrt_pkg::SLOT_W-1:0]   i_slot,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_accepted,
    output logic [pdrt_pkg::SLOT_W-1:0]   o_slot_used,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pdrt_pkg::HALF_W-1:0]   i_cfg_data
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);
    localparam logic [pdrt_pkg::SLOT_W:0] ENT_EXT = (pdrt_pkg::SLOT_W + 1)'(ENTRIES);

    pdrt_pkg::t_state  r_state, n_state;
    pdrt_pkg::t_center r_mem [ENTRIES];
    pdrt_pkg::t_center r_rd_data;
    pdrt_pkg::t_match  match;

    logic [ENTRIES-1:0]             r_valid;
    logic [AW-1:0]                  r_idx;
    logic [AW-1:0]                  r_next_slot;
    logic [pdrt_pkg::HALF_W-1:0]    r_half;
    logic                           r_func;
    logic [pdrt_pkg::POS_W-1:0]     r_px, r_py;
    logic                           r_slot_ok;
    logic                           r_rd_live;
    logic                           r_rd_vld;
    logic                           r_hit;
    logic                           r_out_valid;
    logic                           r_accepted;
    logic [pdrt_pkg::SLOT_W-1:0]    r_slot_used;

    logic in_take;
    logic issue;
    logic commit;
    logic place_wr;
    logic expire_clr;

    assign in_take     = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != pdrt_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_accepted  = r_accepted;
    assign o_slot_used = r_slot_used;

    // outputs of the sequencer
    always_comb begin
        issue  = 1'b0;
        commit = 1'b0;
        case (r_state)
            pdrt_pkg::ST_SCAN:   issue  = 1'b1;
            pdrt_pkg::ST_FINISH: commit = !r_out_valid || !i_out_stall;
            default: ;
        endcase
    end

    assign place_wr   = commit && (r_func == pdrt_pkg::FUNC_PLACE) && !r_hit;
    assign expire_clr = commit && (r_func == pdrt_pkg::FUNC_EXPIRE) && r_hit;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pdrt_pkg::ST_IDLE: begin
                if (in_take) n_state = pdrt_pkg::ST_SCAN;
            end
            pdrt_pkg::ST_SCAN: begin
                if (r_func == pdrt_pkg::FUNC_EXPIRE || r_idx == LAST) begin
                    n_state = pdrt_pkg::ST_WAIT;
                end
            end
            pdrt_pkg::ST_WAIT:   n_state = pdrt_pkg::ST_FINISH;
            pdrt_pkg::ST_FINISH: begin
                if (commit) n_state = pdrt_pkg::ST_IDLE;
            end
            default: n_state = pdrt_pkg::ST_IDLE;
        endcase
    end

    // Center memory: one read, one write port. Writes happen only in FINISH and
    // the next scan read follows a pass through IDLE, so no forwarding.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_idx];
        if (place_wr) begin
            r_mem[r_next_slot] <= '{x: r_px, y: r_py};
        end
    end

    pdrt_window_match u_match (
        .i_center (r_rd_data),
        .i_pos_x  (r_px),
        .i_pos_y  (r_py),
        .i_half   (r_half),
        .o_match  (match)
    );

    // item payload and scan pointer
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_func    <= i_func;
            r_px      <= i_pos_x;
            r_py      <= i_pos_y;
            r_slot_ok <= ({1'b0, i_slot} < ENT_EXT);
            r_idx     <= (i_func == pdrt_pkg::FUNC_PLACE) ? '0 : i_slot[AW-1:0];
        end else if (issue && r_func == pdrt_pkg::FUNC_PLACE) begin
            r_idx <= r_idx + AW'(1);
        end
        r_rd_vld <= r_valid[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pdrt_pkg::ST_IDLE;
            r_valid     <= '0;
            r_next_slot <= '0;
            r_half      <= pdrt_pkg::HALF_RESET;
            r_rd_live   <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
            r_accepted  <= 1'b0;
            r_slot_used <= '0;
        end else begin
            r_state   <= n_state;
            r_rd_live <= issue;

            if (i_cfg_valid && o_cfg_ready) r_half <= i_cfg_data;

            if (in_take) begin
                r_hit <= 1'b0;
            end else if (r_rd_live) begin
                if (r_func == pdrt_pkg::FUNC_PLACE) begin
                    r_hit <= r_hit || (r_rd_vld && match.in_window);
                end else begin
                    r_hit <= r_slot_ok && r_rd_vld && match.exact;
                end
            end

            if (place_wr) begin
                r_valid[r_next_slot] <= 1'b1;
                r_next_slot <= (r_next_slot == LAST) ? '0 : r_next_slot + AW'(1);
            end else if (expire_clr) begin
                r_valid[r_idx] <= 1'b0;
            end

            if (commit) begin
                r_out_valid <= 1'b1;
                r_accepted  <= place_wr || expire_clr;
                r_slot_used <= place_wr ? pdrt_pkg::SLOT_W'(r_next_slot) : '0;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

@@ hdl/pdrt_checker.sv @@
// Port-level checker for the proximity dedup ring table, bound to the top.
// Depends on pdrt_pkg and proximity_dedup_ring_table_top_macros.svh.
`include "proximity_dedup_ring_table_top_macros.svh"

module pdrt_checker #(
    parameter int ENTRIES = 40
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic                        o_accepted,
    input logic [pdrt_pkg::SLOT_W-1:0] o_slot_used
);

    localparam logic [pdrt_pkg::SLOT_W:0] ENT_EXT = (pdrt_pkg::SLOT_W + 1)'(ENTRIES);

    // a stalled result holds
    `PDRT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_accepted) && $stable(o_slot_used),
        "stalled result changed")

    // one item at a time: input stalls right after a transaction
    `PDRT_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_in_valid && !o_in_stall,
        o_in_stall, "input not stalled after transaction")

    // a rejected result reports slot zero
    `PDRT_ASSERT_SAME(a_reject_slot, i_clk, i_rst_n, o_out_valid && !o_accepted,
        o_slot_used == '0, "nonzero slot on rejected result")

    // reported slot stays inside the table
    `PDRT_ASSERT_SAME(a_slot_range, i_clk, i_rst_n, o_out_valid,
        {1'b0, o_slot_used} < ENT_EXT, "slot beyond table")

endmodule

bind proximity_dedup_ring_table_top pdrt_checker #(.ENTRIES(ENTRIES)) u_pdrt_checker (.*);

@@ tb/testbench.sv @@
// Self-checking testbench for proximity_dedup_ring_table_top: directed rows, then random
// place/expire traffic checked against an in-bench model of the ring table.
// Depends on pdrt_pkg and the RTL under hdl/.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POS_W          = pdrt_pkg::POS_W;
    localparam int SLOT_W         = pdrt_pkg::SLOT_W;
    localparam int HALF_W         = pdrt_pkg::HALF_W;
    localparam int TABLE_DEPTH    = 40;
    localparam int POS_MAX        = (1 << POS_W) - 1;
    localparam int SETTLE_CYCLES  = TABLE_DEPTH + 4;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_REPORTS    = 10;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        logic              accepted;
        logic [SLOT_W-1:0] slot_used;
    } t_dedup_result;

    typedef struct {
        t_row_kind         kind;
        logic              func;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [SLOT_W-1:0] slot;
        bit                typed;
        t_dedup_result     want;
        logic [HALF_W-1:0] cfg;
    } t_stim_row;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                i_func      = pdrt_pkg::FUNC_PLACE;
    logic [POS_W-1:0]    i_pos_x     = '0;
    logic [POS_W-1:0]    i_pos_y     = '0;
    logic [SLOT_W-1:0]   i_slot      = '0;
    logic                i_out_stall = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic [HALF_W-1:0]   i_cfg_data  = '0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic                o_accepted;
    logic [SLOT_W-1:0]   o_slot_used;
    logic                o_cfg_ready;

    // model of the ring table
    logic [POS_W-1:0]    ring_x    [TABLE_DEPTH];
    logic [POS_W-1:0]    ring_y    [TABLE_DEPTH];
    logic                ring_live [TABLE_DEPTH];
    int                  ring_next;
    logic [HALF_W-1:0]   half_window_model;

    t_dedup_result       pending_results[$];
    t_stim_row           directed_rows[$];
    int                  mismatch_count = 0;
    int                  quiet_cycles   = 0;
    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;

    // receiver hold-off: main flips the request, the stall process counts it out
    logic                hold_req  = 1'b0;
    logic                hold_seen = 1'b0;
    int                  hold_left = 0;

    proximity_dedup_ring_table_top #(
        .ENTRIES (TABLE_DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_func),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_slot      (i_slot),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_accepted  (o_accepted),
        .o_slot_used (o_slot_used),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic bit in_window(input logic [POS_W-1:0] c, input logic [POS_W-1:0] p);
        int lo;
        int hi;
        lo = int'(c) - int'(half_window_model);
        hi = int'(c) + int'(half_window_model);
        return int'(p) >= lo && int'(p) < hi;
    endfunction

    // Applies one transaction to the model and returns the result it should produce.
    function automatic t_dedup_result dedup_predict(input logic func,
                                                    input logic [POS_W-1:0] px,
                                                    input logic [POS_W-1:0] py,
                                                    input logic [SLOT_W-1:0] slot);
        t_dedup_result res;
        bit            hit;
        int            s;
        res = '0;
        hit = 1'b0;
        if (func == pdrt_pkg::FUNC_PLACE) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (ring_live[i] && in_window(ring_x[i], px) && in_window(ring_y[i], py))
                    hit = 1'b1;
            end
            if (!hit) begin
                s = (ring_next >= TABLE_DEPTH) ? 0 : ring_next;
                ring_x[s]    = px;
                ring_y[s]    = py;
                ring_live[s] = 1'b1;
                ring_next    = (s + 1 >= TABLE_DEPTH) ? 0 : s + 1;
                res.accepted  = 1'b1;
                res.slot_used = SLOT_W'(s);
            end
        end else if (int'(slot) < TABLE_DEPTH && ring_live[slot] &&
                     ring_x[slot] == px && ring_y[slot] == py) begin
            ring_live[slot] = 1'b0;
            ring_x[slot]    = '0;
            ring_y[slot]    = '0;
            res.accepted    = 1'b1;
        end
        return res;
    endfunction

    function automatic void note_mismatch(input string what, input t_dedup_result want,
                                          input t_dedup_result got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s: expected accepted=%0d slot_used=%0d, %s=%0d slot_used=%0d",
                     $realtime, what, want.accepted, want.slot_used, "got accepted",
                     got.accepted, got.slot_used);
    endfunction

    // Point close to a stored center, reaching one pixel past either window edge.
    function automatic logic [POS_W-1:0] near_coord(input logic [POS_W-1:0] c);
        int v;
        v = int'(c) + int'($urandom_range(2 * half_window_model + 1)) - int'(half_window_model) - 1;
        if (v < 0)
            v = 0;
        if (v > POS_MAX)
            v = POS_MAX;
        return POS_W'(v);
    endfunction

    task automatic add_item_row(input logic func, input int x, input int y, input int slot,
                                input bit typed, input logic acc, input int used);
        t_stim_row row;
        row.kind  = ROW_ITEM;
        row.func  = func;
        row.x     = POS_W'(x);
        row.y     = POS_W'(y);
        row.slot  = SLOT_W'(slot);
        row.typed = typed;
        row.want  = '{accepted: acc, slot_used: SLOT_W'(used)};
        row.cfg   = '0;
        directed_rows.push_back(row);
    endtask

    task automatic add_cfg_row(input int value);
        t_stim_row row;
        row.kind  = ROW_CFG;
        row.func  = pdrt_pkg::FUNC_PLACE;
        row.x     = '0;
        row.y     = '0;
        row.slot  = '0;
        row.typed = 1'b0;
        row.want  = '0;
        row.cfg   = HALF_W'(value);
        directed_rows.push_back(row);
    endtask

    // Offers one transaction, waits for it to be taken, then records the expected result.
    task automatic offer_item(input logic func, input logic [POS_W-1:0] x,
                              input logic [POS_W-1:0] y, input logic [SLOT_W-1:0] slot,
                              input bit typed, input t_dedup_result want);
        t_dedup_result model_res;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= func;
        i_pos_x    <= x;
        i_pos_y    <= y;
        i_slot     <= slot;
        do
            @(posedge i_clk);
        while (o_in_stall);
        model_res = dedup_predict(func, x, y, slot);
        pending_results.push_back(typed ? want : model_res);
    endtask

    task automatic drain_and_settle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_half_window(input logic [HALF_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        half_window_model = value;
    endtask

    // Mostly well-formed traffic: places near stored points, expires of live slots.
    task automatic random_item(output logic func, output logic [POS_W-1:0] x,
                               output logic [POS_W-1:0] y, output logic [SLOT_W-1:0] slot);
        int live[$];
        int r;
        int pick;
        int idx;
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (ring_live[i])
                live.push_back(i);
        r    = $urandom_range(99);
        func = pdrt_pkg::FUNC_EXPIRE;
        x    = POS_W'($urandom);
        y    = POS_W'($urandom);
        slot = SLOT_W'($urandom);
        if (r < 55) begin
            func = pdrt_pkg::FUNC_PLACE;
            pick = $urandom_range(3);
            if (pick == 1 && live.size() != 0) begin
                idx = live[$urandom_range(live.size() - 1)];
                x   = near_coord(ring_x[idx]);
                y   = near_coord(ring_y[idx]);
            end else if (pick >= 2) begin
                // dense clusters in the four corners
                x = POS_W'($urandom_range(511) + ($urandom_range(1) ? POS_MAX - 511 : 0));
                y = POS_W'($urandom_range(511) + ($urandom_range(1) ? POS_MAX - 511 : 0));
            end
        end else if (r < 90 && live.size() != 0) begin
            idx  = live[$urandom_range(live.size() - 1)];
            slot = SLOT_W'(idx);
            x    = ring_x[idx];
            y    = ring_y[idx];
            if ($urandom_range(4) == 0) begin
                if ($urandom_range(1))
                    x = x ^ POS_W'(1 << $urandom_range(POS_W - 1));
                else
                    y = y ^ POS_W'(1 << $urandom_range(POS_W - 1));
            end
        end
    endtask

    task automatic run_phase(input logic [HALF_W-1:0] hw, input int send_pct, input int recv_pct,
                             input int count, input bit pressure);
        logic              func;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [SLOT_W-1:0] slot;
        drain_and_settle();
        write_half_window(hw);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        if (pressure)
            hold_req = ~hold_req;
        repeat (count) begin
            random_item(func, x, y, slot);
            offer_item(func, x, y, slot, 1'b0, '0);
        end
    endtask

    // Receiver side: random stall, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen   <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0)
                note_mismatch("unexpected result", '0, '{o_accepted, o_slot_used});
            else if (pending_results[0] !== t_dedup_result'({o_accepted, o_slot_used}))
                note_mismatch("result mismatch", pending_results.pop_front(),
                              '{o_accepted, o_slot_used});
            else
                void'(pending_results.pop_front());
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL proximity_dedup_ring_table_top");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            ring_x[i]    = '0;
            ring_y[i]    = '0;
            ring_live[i] = 1'b0;
        end
        ring_next         = 0;
        half_window_model = pdrt_pkg::HALF_RESET;

        // reset window of 24 is in force until the first write
        add_item_row(pdrt_pkg::FUNC_PLACE, 0, 0, 0, 1, 1'b1, 0);
        add_item_row(pdrt_pkg::FUNC_PLACE, 0, 0, 0, 1, 1'b0, 0);
        add_item_row(pdrt_pkg::FUNC_PLACE, 23, 23, 63, 1, 1'b0, 0);  // just inside upper edge
        add_item_row(pdrt_pkg::FUNC_PLACE, 24, 0, 0, 1, 1'b1, 1);    // upper edge is exclusive
        add_item_row(pdrt_pkg::FUNC_PLACE, POS_MAX, POS_MAX, 63, 1, 1'b1, 2);
        // lower edge inclusive
        add_item_row(pdrt_pkg::FUNC_PLACE, POS_MAX - 24, POS_MAX - 24, 0, 1, 1'b0, 0);
        add_item_row(pdrt_pkg::FUNC_PLACE, POS_MAX - 25, POS_MAX, 0, 0, 1'b0, 0);
        add_item_row(pdrt_pkg::FUNC_EXPIRE, 0, 0, 63, 1, 1'b0, 0);   // slot out of range
        add_item_row(pdrt_pkg::FUNC_EXPIRE, 0, 0, TABLE_DEPTH, 1, 1'b0, 0);
        add_item_row(pdrt_pkg::FUNC_EXPIRE, 1, 0, 0, 1, 1'b0, 0);    // point does not match
        add_item_row(pdrt_pkg::FUNC_EXPIRE, 0, 0, 0, 1, 1'b1, 0);
        add_item_row(pdrt_pkg::FUNC_EXPIRE, 0, 0, 0, 1, 1'b0, 0);    // already cleared
        add_item_row(pdrt_pkg::FUNC_EXPIRE, 0, 0, TABLE_DEPTH - 1, 1, 1'b0, 0);
        add_cfg_row(0);                                              // empty windows
        add_item_row(pdrt_pkg::FUNC_PLACE, 0, 0, 0, 0, 1'b0, 0);
        add_item_row(pdrt_pkg::FUNC_PLACE, 0, 0, 0, 0, 1'b0, 0);
        add_cfg_row(255);
        add_item_row(pdrt_pkg::FUNC_PLACE, 200, 200, 0, 0, 1'b0, 0);
        add_item_row(pdrt_pkg::FUNC_PLACE, 255, 0, 0, 0, 1'b0, 0);
        add_item_row(pdrt_pkg::FUNC_PLACE, 16384, 16384, 0, 0, 1'b0, 0);
        add_item_row(pdrt_pkg::FUNC_EXPIRE, 0, 0, 5, 0, 1'b0, 0);
        add_item_row(pdrt_pkg::FUNC_PLACE, POS_MAX, 0, 0, 0, 1'b0, 0);
        add_item_row(pdrt_pkg::FUNC_PLACE, 0, POS_MAX, 0, 0, 1'b0, 0);
        add_cfg_row(24);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                drain_and_settle();
                write_half_window(directed_rows[i].cfg);
            end else begin
                offer_item(directed_rows[i].func, directed_rows[i].x, directed_rows[i].y,
                           directed_rows[i].slot, directed_rows[i].typed,
                           directed_rows[i].want);
            end
        end

        run_phase(HALF_W'(0), 0, 0, 120, 1'b1);
        run_phase(HALF_W'(255), 87, 0, 140, 1'b0);
        run_phase(HALF_W'(1), 0, 87, 140, 1'b0);
        run_phase(HALF_W'($urandom_range(2, 80)), 8, 8, 200, 1'b0);
        run_phase(HALF_W'(24), 0, 0, 100, 1'b0);
        run_phase(HALF_W'($urandom_range(2, 255)), 0, 87, 100, 1'b0);

        drain_and_settle();
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("PASS proximity_dedup_ring_table_top");
        end else begin
            $display("FAIL proximity_dedup_ring_table_top");
        end
        $finish;
    end

endmodule

@@ proximity_dedup_ring_table_top.f @@
+incdir+hdl
hdl/pdrt_pkg.sv
hdl/pdrt_window_match.sv
hdl/proximity_dedup_ring_table_top.sv
hdl/pdrt_checker.sv
tb/testbench.sv
